/* rtl/core/tqle_pkg.sv */
package tqle_pkg;

    localparam int NUM_STATES_DEF = 8;
    localparam int Q_WIDTH_DEF    = 24;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int RND_W    = 16;
    localparam int REWARD_W = 16;
    localparam int GAIN_W   = 8;
    localparam int CFG_W    = 8;

    localparam logic [2:0]        GOAL_RESET   = 3'd5;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 8'd205;
    localparam logic [3:0]        ACTIVE_RESET = 4'd6;

    localparam logic [1:0] KIND_WR_REWARD = 2'd0;
    localparam logic [1:0] KIND_STEP      = 2'd1;
    localparam logic [1:0] KIND_QUERY     = 2'd2;
    localparam logic [1:0] KIND_SET_STATE = 2'd3;

    localparam logic [1:0] CFG_GOAL   = 2'd0;
    localparam logic [1:0] CFG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_ACTIVE = 2'd2;

    localparam logic [1:0] SCAN_COUNT = 2'd0;
    localparam logic [1:0] SCAN_FIND  = 2'd1;
    localparam logic [1:0] SCAN_MAX   = 2'd2;
    localparam logic [1:0] SCAN_BEST  = 2'd3;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [2:0]                 state_index;
        logic [2:0]                 action_index;
        logic signed [REWARD_W-1:0] reward_value;
        logic [RND_W-1:0]           action_random;
        logic [RND_W-1:0]           restart_random;
    } tqle_in_t;

    typedef struct packed {
        logic [2:0]  chosen_action;
        logic [2:0]  new_state;
        logic        goal_reached;
        logic        no_action;
        logic [23:0] updated_q;
        logic [2:0]  top_action;
    } tqle_out_t;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       scan_start;
        logic       scan_run;
        logic [1:0] scan_mode;
        logic       mod_start;
        logic       mod_restart;
        logic       take_pick;
        logic       mul;
        logic       add;
        logic       commit;
        logic       restart;
        logic       wr_reward;
        logic       set_state;
        logic       emit;
        logic       none;
    } tqle_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       scan_done;
        logic       count_zero;
        logic       goal_hit;
        logic       row_ok;
        logic       mod_done;
        logic       out_free;
        logic [1:0] kind;
    } tqle_sts_t;

endpackage

/* rtl/core/tqle_mod.sv */
module tqle_mod #(
    parameter int DIV_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tqle_pkg::RND_W-1:0]    dividend,
    input  logic [DIV_W-1:0]              divisor,
    output logic                          done,
    output logic [DIV_W-1:0]              rem
);

    localparam int CNT_W = $clog2(tqle_pkg::RND_W + 1);

    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [tqle_pkg::RND_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]           dvs_reg, dvs_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [DIV_W:0]             trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[tqle_pkg::RND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(tqle_pkg::RND_W);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = !busy_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/core/tqle_dp.sv */
module tqle_dp #(
    parameter int NUM_STATES = tqle_pkg::NUM_STATES_DEF,
    parameter int Q_WIDTH    = tqle_pkg::Q_WIDTH_DEF,
    parameter int FRAC_BITS  = tqle_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tqle_pkg::tqle_cmd_t           cmd,
    output tqle_pkg::tqle_sts_t           sts,
    input  tqle_pkg::tqle_in_t            item,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [tqle_pkg::CFG_W-1:0]    cfg_data,
    output tqle_pkg::tqle_out_t           result,
    output logic                          result_valid,
    input  logic                          result_ready
);

    localparam int SW     = $clog2(NUM_STATES);
    localparam int CW     = $clog2(NUM_STATES + 1);
    localparam int NCELLS = NUM_STATES * NUM_STATES;
    localparam int AW     = $clog2(NCELLS);
    localparam int GW     = (SW > 3) ? SW : 3;
    localparam int PW     = Q_WIDTH + tqle_pkg::GAIN_W;
    localparam int RW     = tqle_pkg::REWARD_W - 1;
    localparam int RSH_W  = RW + FRAC_BITS;
    localparam int SUMW   = ((RSH_W > Q_WIDTH) ? RSH_W : Q_WIDTH) + 1;

    logic [tqle_pkg::REWARD_W-1:0] reward_mem [NCELLS];
    logic [Q_WIDTH-1:0]            q_mem [NCELLS];
    logic [tqle_pkg::REWARD_W-1:0] rw_rd_reg;
    logic [Q_WIDTH-1:0]            q_rd_reg;

    logic [2:0]                  goal_reg, goal_next;
    logic [tqle_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic [3:0]                  active_reg, active_next;
    logic [SW-1:0]               cur_reg, cur_next;
    logic [AW-1:0]               clr_addr_reg, clr_addr_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [SW-1:0]               rd_idx_reg, rd_idx_next;
    logic [1:0]                  mode_reg, mode_next;
    logic                        res_vld_reg, res_vld_next;

    tqle_pkg::tqle_in_t          item_reg, item_next;
    tqle_pkg::tqle_out_t         res_reg, res_next;
    logic [SW-1:0]               row_reg, row_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               pick_reg, pick_next;
    logic                        found_reg, found_next;
    logic [SW-1:0]               next_reg, next_nxt;
    logic [RW-1:0]               rsel_reg, rsel_next;
    logic [Q_WIDTH-1:0]          maxq_reg, maxq_next;
    logic [SW-1:0]               best_reg, best_next;
    logic [PW-1:0]               prod_reg, prod_next;
    logic [Q_WIDTH-1:0]          qnew_reg, qnew_next;

    logic [CW-1:0]               eff_act;
    logic                        row_ok;
    logic                        col_ok;
    logic                        goal_hit;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        rw_we;
    logic [AW-1:0]               rw_waddr;
    logic [tqle_pkg::REWARD_W-1:0] rw_wdata;
    logic                        q_we;
    logic [AW-1:0]               q_waddr;
    logic [Q_WIDTH-1:0]          q_wdata;
    logic [SUMW-1:0]             sum;
    logic                        mod_done;
    logic [CW-1:0]               mod_rem;
    logic [CW-1:0]               mod_divisor;
    logic [tqle_pkg::RND_W-1:0]  mod_dividend;
    logic                        is_step;

    function automatic logic [AW-1:0] cell_addr(input logic [SW-1:0] r, input logic [SW-1:0] c);
        cell_addr = AW'(r) * AW'(NUM_STATES) + AW'(c);
    endfunction

    always_comb
    begin
        if (active_reg == 4'd0)
        begin
            eff_act = CW'(1);
        end
        else if (32'(active_reg) >= 32'(NUM_STATES))
        begin
            eff_act = CW'(NUM_STATES);
        end
        else
        begin
            eff_act = CW'(active_reg);
        end
    end

    assign row_ok   = 32'(item_reg.state_index) < 32'(NUM_STATES);
    assign col_ok   = 32'(item_reg.action_index) < 32'(NUM_STATES);
    assign goal_hit = GW'(next_reg) == GW'(goal_reg);
    assign rd_en    = cmd.scan_run && (idx_reg != eff_act);
    assign rd_addr  = cell_addr(row_reg, idx_reg[SW-1:0]);

    assign rw_we    = cmd.clr || (cmd.wr_reward && row_ok && col_ok);
    assign rw_waddr = cmd.clr ? clr_addr_reg
                              : cell_addr(SW'(item_reg.state_index), SW'(item_reg.action_index));
    assign rw_wdata = cmd.clr ? '1 : item_reg.reward_value;
    assign q_we     = cmd.clr || cmd.commit;
    assign q_waddr  = cmd.clr ? clr_addr_reg : cell_addr(cur_reg, next_reg);
    assign q_wdata  = cmd.clr ? '0 : qnew_reg;

    assign sum = SUMW'({rsel_reg, {FRAC_BITS{1'b0}}}) + SUMW'(prod_reg[PW-1:tqle_pkg::GAIN_W]);

    assign mod_dividend = cmd.mod_restart ? item_reg.restart_random : item_reg.action_random;
    assign mod_divisor  = cmd.mod_restart ? eff_act : count_reg;
    assign is_step      = (item_reg.kind == tqle_pkg::KIND_STEP) && !cmd.none;

    tqle_mod #(
        .DIV_W (CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        goal_next     = goal_reg;
        gain_next     = gain_reg;
        active_next   = active_reg;
        cur_next      = cur_reg;
        clr_addr_next = clr_addr_reg;
        idx_next      = idx_reg;
        rd_vld_next   = rd_vld_reg;
        rd_idx_next   = rd_idx_reg;
        mode_next     = mode_reg;
        res_vld_next  = res_vld_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        row_next      = row_reg;
        count_next    = count_reg;
        pick_next     = pick_reg;
        found_next    = found_reg;
        next_nxt      = next_reg;
        rsel_next     = rsel_reg;
        maxq_next     = maxq_reg;
        best_next     = best_reg;
        prod_next     = prod_reg;
        qnew_next     = qnew_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                tqle_pkg::CFG_GOAL:   goal_next   = cfg_data[2:0];
                tqle_pkg::CFG_GAIN:   gain_next   = cfg_data;
                tqle_pkg::CFG_ACTIVE: active_next = cfg_data[3:0];
                default: ;
            endcase
        end

        if (cmd.clr)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end

        if (cmd.load)
        begin
            item_next = item;
        end

        if (cmd.scan_start)
        begin
            mode_next   = cmd.scan_mode;
            idx_next    = '0;
            rd_vld_next = 1'b0;
            count_next  = '0;
            found_next  = 1'b0;
            maxq_next   = '0;
            best_next   = '0;
            case (cmd.scan_mode)
                tqle_pkg::SCAN_MAX:  row_next = next_reg;
                tqle_pkg::SCAN_BEST: row_next = SW'(item_reg.state_index);
                default:             row_next = cur_reg;
            endcase
        end

        if (cmd.scan_run)
        begin
            rd_vld_next = rd_en;
            rd_idx_next = idx_reg[SW-1:0];
            if (rd_en)
            begin
                idx_next = idx_reg + CW'(1);
            end
            if (rd_vld_reg)
            begin
                case (mode_reg)
                    tqle_pkg::SCAN_COUNT:
                    begin
                        if (!rw_rd_reg[RW])
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    tqle_pkg::SCAN_FIND:
                    begin
                        if (!rw_rd_reg[RW] && !found_reg)
                        begin
                            if (pick_reg == '0)
                            begin
                                found_next = 1'b1;
                                next_nxt   = rd_idx_reg;
                                rsel_next  = rw_rd_reg[RW-1:0];
                            end
                            else
                            begin
                                pick_next = pick_reg - CW'(1);
                            end
                        end
                    end
                    tqle_pkg::SCAN_MAX:
                    begin
                        if (!rw_rd_reg[RW] && (q_rd_reg > maxq_reg))
                        begin
                            maxq_next = q_rd_reg;
                        end
                    end
                    default:
                    begin
                        if (q_rd_reg > maxq_reg)
                        begin
                            maxq_next = q_rd_reg;
                            best_next = rd_idx_reg;
                        end
                    end
                endcase
            end
        end

        if (cmd.take_pick)
        begin
            pick_next = mod_rem;
        end

        if (cmd.mul)
        begin
            prod_next = PW'(gain_reg) * PW'(maxq_reg);
        end

        if (cmd.add)
        begin
            if (sum > SUMW'({Q_WIDTH{1'b1}}))
            begin
                qnew_next = '1;
            end
            else
            begin
                qnew_next = sum[Q_WIDTH-1:0];
            end
        end

        if (cmd.commit && !goal_hit)
        begin
            cur_next = next_reg;
        end

        if (cmd.restart)
        begin
            cur_next = SW'(mod_rem);
        end

        if (cmd.set_state && row_ok)
        begin
            cur_next = SW'(item_reg.state_index);
        end

        if (result_ready)
        begin
            res_vld_next = 1'b0;
        end
        if (cmd.emit)
        begin
            res_vld_next           = 1'b1;
            res_next.chosen_action = is_step ? 3'(next_reg) : 3'd0;
            res_next.new_state     = 3'(cur_reg);
            res_next.goal_reached  = is_step && goal_hit;
            res_next.no_action     = cmd.none;
            res_next.updated_q     = is_step ? 24'(qnew_reg) : 24'd0;
            res_next.top_action    = ((item_reg.kind == tqle_pkg::KIND_QUERY) && row_ok)
                                     ? 3'(best_reg) : 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg     <= tqle_pkg::GOAL_RESET;
            gain_reg     <= tqle_pkg::GAIN_RESET;
            active_reg   <= tqle_pkg::ACTIVE_RESET;
            cur_reg      <= '0;
            clr_addr_reg <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            mode_reg     <= tqle_pkg::SCAN_COUNT;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            goal_reg     <= goal_next;
            gain_reg     <= gain_next;
            active_reg   <= active_next;
            cur_reg      <= cur_next;
            clr_addr_reg <= clr_addr_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            mode_reg     <= mode_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        item_reg   <= item_next;
        res_reg    <= res_next;
        row_reg    <= row_next;
        count_reg  <= count_next;
        pick_reg   <= pick_next;
        found_reg  <= found_next;
        next_reg   <= next_nxt;
        rsel_reg   <= rsel_next;
        maxq_reg   <= maxq_next;
        best_reg   <= best_next;
        prod_reg   <= prod_next;
        qnew_reg   <= qnew_next;
    end

    always_ff @(posedge clk)
    begin
        if (rw_we)
        begin
            reward_mem[rw_waddr] <= rw_wdata;
        end
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (rd_en)
        begin
            rw_rd_reg <= reward_mem[rd_addr];
            q_rd_reg  <= q_mem[rd_addr];
        end
    end

    assign sts.clr_last   = clr_addr_reg == AW'(NCELLS - 1);
    assign sts.scan_done  = (idx_reg == eff_act) && !rd_vld_reg;
    assign sts.count_zero = count_reg == '0;
    assign sts.goal_hit   = goal_hit;
    assign sts.row_ok     = row_ok;
    assign sts.mod_done   = mod_done;
    assign sts.out_free   = !res_vld_reg || result_ready;
    assign sts.kind       = item_reg.kind;

    assign result       = res_reg;
    assign result_valid = res_vld_reg;

endmodule

/* rtl/core/tqle_ctrl.sv */
module tqle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  tqle_pkg::tqle_sts_t sts,
    output tqle_pkg::tqle_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DECODE    = 4'd2;
    localparam logic [3:0] S_SCAN_BEST = 4'd3;
    localparam logic [3:0] S_SCAN_CNT  = 4'd4;
    localparam logic [3:0] S_MOD_PICK  = 4'd5;
    localparam logic [3:0] S_SCAN_FIND = 4'd6;
    localparam logic [3:0] S_SCAN_MAX  = 4'd7;
    localparam logic [3:0] S_MUL       = 4'd8;
    localparam logic [3:0] S_ADD       = 4'd9;
    localparam logic [3:0] S_COMMIT    = 4'd10;
    localparam logic [3:0] S_MOD_RST   = 4'd11;
    localparam logic [3:0] S_EMIT      = 4'd12;
    localparam logic [3:0] S_EMIT_NONE = 4'd13;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.kind)
                    tqle_pkg::KIND_WR_REWARD:
                    begin
                        cmd.wr_reward = 1'b1;
                        state_next    = S_EMIT;
                    end
                    tqle_pkg::KIND_SET_STATE:
                    begin
                        cmd.set_state = 1'b1;
                        state_next    = S_EMIT;
                    end
                    tqle_pkg::KIND_QUERY:
                    begin
                        if (sts.row_ok)
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = tqle_pkg::SCAN_BEST;
                            state_next     = S_SCAN_BEST;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    default:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = tqle_pkg::SCAN_COUNT;
                        state_next     = S_SCAN_CNT;
                    end
                endcase
            end
            S_SCAN_BEST:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_SCAN_CNT:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.count_zero)
                    begin
                        state_next = S_EMIT_NONE;
                    end
                    else
                    begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_MOD_PICK;
                    end
                end
            end
            S_MOD_PICK:
            begin
                if (sts.mod_done)
                begin
                    cmd.take_pick  = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = tqle_pkg::SCAN_FIND;
                    state_next     = S_SCAN_FIND;
                end
            end
            S_SCAN_FIND:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.scan_run   = 1'b0;
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = tqle_pkg::SCAN_MAX;
                    state_next     = S_SCAN_MAX;
                end
            end
            S_SCAN_MAX:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (sts.goal_hit)
                begin
                    cmd.mod_start   = 1'b1;
                    cmd.mod_restart = 1'b1;
                    state_next      = S_MOD_RST;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_MOD_RST:
            begin
                if (sts.mod_done)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.none   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = state_reg == S_IDLE;

endmodule

/* rtl/core/tabular_q_learning_engine_top.sv */
// channel   direction  handshake                  payload
// item      in         item_valid / item_ready    item (tqle_in_t)
// result    out        result_valid / result_ready result (tqle_out_t)
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// after reset both tables are swept, cell by cell, before the first item
// reward write, set state: decode, then emit; query: one row scan (A = active states)
// learning step: three row scans (count, find, max) of A cells through the single table
// read port, with a pass of the bit-serial modulo unit before the find scan and one more
// for the restart when the goal is hit; with no allowed action it ends after the count scan
// a finished result waits in the output register while the next item is taken in
module tabular_q_learning_engine_top #(
    parameter int NUM_STATES = tqle_pkg::NUM_STATES_DEF,
    parameter int Q_WIDTH    = tqle_pkg::Q_WIDTH_DEF,
    parameter int FRAC_BITS  = tqle_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  tqle_pkg::tqle_in_t         item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output tqle_pkg::tqle_out_t        result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [tqle_pkg::CFG_W-1:0] cfg_data
);

    tqle_pkg::tqle_cmd_t cmd;
    tqle_pkg::tqle_sts_t sts;

    assign cfg_ready = 1'b1;

    tqle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    tqle_dp #(
        .NUM_STATES (NUM_STATES),
        .Q_WIDTH    (Q_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item         (item),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while another is in work");

    a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (NUM_STATES >= 8) || (32'(result.new_state) < 32'(NUM_STATES)))
        else $error("new state out of range");

    a_no_action_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.no_action |-> !result.goal_reached
            && (result.updated_q == 24'd0) && (result.chosen_action == 3'd0))
        else $error("no-action result carries step data");

endmodule
